### sv/dasu_pkg.sv
// Package for the storage-pack address sequencer.
// Holds payload structs, operation and register codes, and the control-line constants.
// No dependencies.
package dasu_pkg;

    // Operation codes of an input item
    localparam logic [1:0] OP_DIR_WR  = 2'd0;
    localparam logic [1:0] OP_CTL_WR  = 2'd1;
    localparam logic [1:0] OP_DATA_RD = 2'd2;
    localparam logic [1:0] OP_CTL_RD  = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_ONE_PAGED = 2'd0;
    localparam logic [1:0] CFG_ONE_SIZE  = 2'd1;
    localparam logic [1:0] CFG_TWO_PAGED = 2'd2;
    localparam logic [1:0] CFG_TWO_SIZE  = 2'd3;

    // Slot select codes on control-line bits 6:4
    localparam logic [2:0] SEL_ONE = 3'b110;
    localparam logic [2:0] SEL_TWO = 3'b101;

    localparam logic [7:0] ALL_OUT = 8'hff;

    // Control-line bit positions
    localparam int CLK_BIT     = 0;
    localparam int RESET_BIT   = 1;
    localparam int PROG_BIT    = 2;
    localparam int DISABLE_BIT = 7;

    localparam logic [18:0] PAGE_BYTES = 19'd256;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] write_value;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  read_value;
        logic [17:0] pack_address;
        logic        address_valid;
        logic        slot_index;
    } out_item_t;

    // Update request from the bus side to one slot
    typedef struct packed {
        logic en;
        logic clk_edge;
        logic prog_fall;
        logic line_reset;
    } slot_cmd_t;

    // Address view of one slot
    typedef struct packed {
        logic [18:0] addr;
        logic        hit;
    } slot_stat_t;

endpackage

### sv/dasu_slot.sv
// Byte and page counters of one pack slot, with wrap logic and address compare.
// Depends on dasu_pkg.
module dasu_slot
    import dasu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       paged,
    input  logic [5:0] units,
    input  slot_cmd_t  cmd,
    output slot_stat_t stat
);

    logic [17:0] byte_reg, byte_next;
    logic [9:0]  page_reg, page_next;
    logic [18:0] pack_bytes;
    logic [18:0] byte_lim;
    logic [18:0] byte_inc;
    logic [10:0] page_lim;
    logic [10:0] page_inc;

    always_comb
    begin
        pack_bytes = {units, 13'b0};
        byte_lim   = paged ? PAGE_BYTES : pack_bytes;
        byte_inc   = {1'b0, byte_reg} + 19'd1;
        page_lim   = {units, 5'b0};
        page_inc   = {1'b0, page_reg} + 11'd1;
        byte_next  = byte_reg;
        page_next  = page_reg;
        if (cmd.en)
        begin
            if (cmd.clk_edge)
            begin
                byte_next = (byte_inc >= byte_lim) ? 18'd0 : byte_inc[17:0];
            end
            if (cmd.prog_fall)
            begin
                page_next = (page_inc >= page_lim) ? 10'd0 : page_inc[9:0];
            end
            // reset line that was high clears both counters, after any advance
            if (cmd.line_reset)
            begin
                byte_next = 18'd0;
                page_next = 10'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg <= 18'd0;
            page_reg <= 10'd0;
        end
        else
        begin
            byte_reg <= byte_next;
            page_reg <= page_next;
        end
    end

    always_comb
    begin
        stat.addr = paged ? ({1'b0, byte_reg} + {1'b0, page_reg, 8'b0}) : {1'b0, byte_reg};
        stat.hit  = (units != 6'd0) && (stat.addr < pack_bytes);
    end

endmodule

### sv/datapack_address_sequencer_unit.sv
// Top level of the two-slot storage-pack address sequencer.
// Depends on dasu_pkg and dasu_slot.
//
// Usage:
//   Input channel (in_valid/in_ready/in_data) carries one bus access: write
//   direction, write control lines, read data bus or read control lines.
//   Output channel (out_valid/out_ready/out_data) returns exactly one result
//   per access: latch value on a control read, pack address and valid flag on
//   a data read, zeros otherwise.
//   Configuration port (cfg_we/cfg_index/cfg_data) sets paged mode and size
//   of each slot; write it only while no access is in flight.
//   The result is registered and appears in the cycle after the input transfer.
//   Throughput: one access per cycle while results are taken; all state
//   updates for an access are done in that cycle, in the top and slot units.
//   Reset clears the direction register, control latch, slot counters and
//   configuration registers; the output register starts empty.
//   When the receiver stalls, the result holds in the output register and
//   in_ready drops until it is taken; an access is still accepted in the
//   same cycle in which the pending result leaves.
module datapack_address_sequencer_unit
    import dasu_pkg::*;
#(
    parameter int MAX_SIZE_UNITS = 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [5:0] cfg_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  in_item_t   in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output out_item_t  out_data
);

    localparam logic [5:0] MAX_UNITS = 6'(MAX_SIZE_UNITS);

    logic       one_paged_reg, two_paged_reg;
    logic [5:0] one_size_reg, two_size_reg;
    logic [5:0] one_units, two_units;
    logic [7:0] dir_reg, dir_next;
    logic [7:0] latch_reg, latch_next;
    logic       out_valid_reg;
    out_item_t  out_reg, out_next;
    logic       accept;
    logic       ctl_take;
    logic [2:0] wr_sel, rd_sel;
    slot_cmd_t  cmd_one, cmd_two, cmd_common;
    slot_stat_t stat_one, stat_two, stat_sel;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            one_paged_reg <= 1'b0;
            one_size_reg  <= 6'd0;
            two_paged_reg <= 1'b0;
            two_size_reg  <= 6'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ONE_PAGED: one_paged_reg <= cfg_data[0];
                CFG_ONE_SIZE:  one_size_reg  <= cfg_data;
                CFG_TWO_PAGED: two_paged_reg <= cfg_data[0];
                CFG_TWO_SIZE:  two_size_reg  <= cfg_data;
                default:       one_paged_reg <= one_paged_reg;
            endcase
        end
    end

    assign one_units = (one_size_reg > MAX_UNITS) ? MAX_UNITS : one_size_reg;
    assign two_units = (two_size_reg > MAX_UNITS) ? MAX_UNITS : two_size_reg;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign ctl_take = accept && (in_data.operation == OP_CTL_WR) && (dir_reg == ALL_OUT);
    assign wr_sel   = in_data.write_value[6:4];
    assign rd_sel   = latch_reg[6:4];

    always_comb
    begin
        cmd_common.en         = 1'b0;
        cmd_common.clk_edge   = latch_reg[CLK_BIT] ^ in_data.write_value[CLK_BIT];
        cmd_common.prog_fall  = latch_reg[PROG_BIT] & ~in_data.write_value[PROG_BIT];
        cmd_common.line_reset = latch_reg[RESET_BIT];
        cmd_one               = cmd_common;
        cmd_two               = cmd_common;
        cmd_one.en            = ctl_take && (wr_sel == SEL_ONE);
        cmd_two.en            = ctl_take && (wr_sel == SEL_TWO);
    end

    dasu_slot u_slot_one (
        .clk   (clk),
        .rst_n (rst_n),
        .paged (one_paged_reg),
        .units (one_units),
        .cmd   (cmd_one),
        .stat  (stat_one)
    );

    dasu_slot u_slot_two (
        .clk   (clk),
        .rst_n (rst_n),
        .paged (two_paged_reg),
        .units (two_units),
        .cmd   (cmd_two),
        .stat  (stat_two)
    );

    always_comb
    begin
        dir_next   = dir_reg;
        latch_next = latch_reg;
        stat_sel   = (rd_sel == SEL_TWO) ? stat_two : stat_one;
        out_next   = '0;
        case (in_data.operation)
            OP_DIR_WR:
            begin
                dir_next = in_data.write_value;
            end
            OP_CTL_WR:
            begin
                if (dir_reg == ALL_OUT)
                begin
                    latch_next = in_data.write_value;
                end
            end
            OP_DATA_RD:
            begin
                if ((rd_sel == SEL_ONE) || (rd_sel == SEL_TWO))
                begin
                    out_next.slot_index = (rd_sel == SEL_TWO);
                    if (stat_sel.hit && !latch_reg[DISABLE_BIT])
                    begin
                        out_next.address_valid = 1'b1;
                        out_next.pack_address  = stat_sel.addr[17:0];
                    end
                end
            end
            OP_CTL_RD:
            begin
                out_next.read_value = latch_reg;
            end
            default:
            begin
                out_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_reg       <= 8'd0;
            latch_reg     <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                dir_reg       <= dir_next;
                latch_reg     <= latch_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, loaded on each input transfer
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_ctl_ignored: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (in_data.operation == OP_CTL_WR) && (dir_reg != ALL_OUT))
        |=> $stable(latch_reg))
        else $error("control write taken while direction not all-out");

    a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg)
        else $error("transfer accepted without a result");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.address_valid) |-> (out_reg.pack_address == 18'd0))
        else $error("address present on invalid read");

    a_read_kinds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_reg.address_valid || out_reg.slot_index))
        |-> (out_reg.read_value == 8'd0))
        else $error("data read and control read mixed in one result");

endmodule
